[rtl/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, codes and constants of the LED pattern controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  // Number of user LEDs driven by the block (1 to 3)
  localparam int NUM_USER_LEDS = 3;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int NOW_W     = 32;
  localparam int LINK_ST_W = 3;
  localparam int IDX_W     = 2;
  localparam int MODE_W    = 3;
  localparam int PERIOD_W  = 32;
  localparam int CFG_W     = 16;
  localparam int RGB_W     = 3;
  localparam int USER_W    = 3;
  localparam int SEL_W     = 4;
  localparam int PHASE_W   = 10;

  // Request types
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LINK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_USER = 2'd2;

  // Link states
  localparam logic [LINK_ST_W-1:0] LINK_INIT    = 3'd0;
  localparam logic [LINK_ST_W-1:0] LINK_PREOP   = 3'd1;
  localparam logic [LINK_ST_W-1:0] LINK_OPER    = 3'd2;
  localparam logic [LINK_ST_W-1:0] LINK_STOPPED = 3'd3;

  // Colours, bit0 red, bit1 green, bit2 blue
  localparam logic [RGB_W-1:0] COL_WHITE = 3'h7;
  localparam logic [RGB_W-1:0] COL_BLUE  = 3'h4;
  localparam logic [RGB_W-1:0] COL_RED   = 3'h1;

  // User LED modes
  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEARTBEAT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ONE_SHOT  = 3'd4;

  // Reset value of the link blink period in ms
  localparam logic [CFG_W-1:0] LINK_PERIOD_RST = 16'd500;

  // Heartbeat: 1000 ms cycle, lit below 100 ms and between 200 and 300 ms
  localparam logic [PHASE_W-1:0] HB_CYCLE_MS = 10'd1000;
  localparam logic [PHASE_W-1:0] HB_ON1_END  = 10'd100;
  localparam logic [PHASE_W-1:0] HB_ON2_BEG  = 10'd200;
  localparam logic [PHASE_W-1:0] HB_ON2_END  = 10'd300;

  // floor(n / 1000) = (n * DIV_RECIP) >> DIV_SHIFT, exact for any 32-bit n
  localparam logic [NOW_W-1:0] DIV_RECIP = 32'd2199023256;
  localparam int               DIV_SHIFT = 41;

  // One request as taken from the input channel
  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [NOW_W-1:0]     now_ms;
    logic [LINK_ST_W-1:0] link_state;
    logic [IDX_W-1:0]     led_num;
    logic [MODE_W-1:0]    led_mode;
    logic [PERIOD_W-1:0]  interval_ms;
  } item_t;

  // Heartbeat pattern for a phase within the 1000 ms cycle
  function automatic logic hb_lit(input logic [PHASE_W-1:0] phase);
    hb_lit = (phase < HB_ON1_END) || ((phase > HB_ON2_BEG) && (phase < HB_ON2_END));
  endfunction

endpackage

`default_nettype wire

[rtl/lpc_in_stage.sv]
// ----------------------------------------------------------------------------
// lpc_in_stage
// Input register and millisecond-phase stage: captures each request and
// works out now_ms mod 1000 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_in_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lpc_pkg::item_t                in_item,
  input  wire logic                          s2_take,
  output logic                               s2_valid,
  output lpc_pkg::item_t                     s2_item,
  output logic [lpc_pkg::PHASE_W-1:0]        s2_phase
);

  logic                           s1_vld_r;
  lpc_pkg::item_t                 s1_item_r;
  logic                           s2_vld_r;
  lpc_pkg::item_t                 s2_item_r;
  logic [lpc_pkg::PHASE_W-1:0]    q_lo_r;
  logic                           s2_free;
  logic                           s1_adv;
  logic [2*lpc_pkg::NOW_W-1:0]    prod;
  logic [2*lpc_pkg::PHASE_W-1:0]  q_mul;

  // advance when the next stage frees up
  assign s2_free  = !s2_vld_r || s2_take;
  assign s1_adv   = s1_vld_r && s2_free;
  assign in_ready = !s1_vld_r || s1_adv;

  // quotient by 1000; only its low bits matter for the phase
  assign prod = 64'(s1_item_r.now_ms) * 64'(lpc_pkg::DIV_RECIP);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      s2_item_r <= s1_item_r;
      q_lo_r    <= prod[lpc_pkg::DIV_SHIFT +: lpc_pkg::PHASE_W];
    end
  end

  // phase = now - 1000 * q, which always fits in ten bits
  assign q_mul    = 20'(q_lo_r) * 20'(lpc_pkg::HB_CYCLE_MS);
  assign s2_phase = s2_item_r.now_ms[lpc_pkg::PHASE_W-1:0] - q_mul[lpc_pkg::PHASE_W-1:0];
  assign s2_valid = s2_vld_r;
  assign s2_item  = s2_item_r;

endmodule

`default_nettype wire

[rtl/lpc_link.sv]
// ----------------------------------------------------------------------------
// lpc_link
// Link-status RGB LED: state-to-colour mapping, blink timing and the
// blink period register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_link (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [lpc_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         step,
  input  wire lpc_pkg::item_t               item,
  output logic [lpc_pkg::RGB_W-1:0]         rgb_nxt
);

  logic [lpc_pkg::CFG_W-1:0]     period_r;
  logic [lpc_pkg::LINK_ST_W-1:0] state_r,  state_nxt;
  logic                          blink_r,  blink_nxt;
  logic [lpc_pkg::RGB_W-1:0]     colour_r, colour_nxt;
  logic [lpc_pkg::NOW_W-1:0]     toggle_r, toggle_nxt;
  logic                          lit_r,    lit_nxt;
  logic [lpc_pkg::NOW_W-1:0]     elapsed;

  assign elapsed = item.now_ms - toggle_r;

  // next link state for the request in hand
  always_comb begin
    state_nxt  = state_r;
    blink_nxt  = blink_r;
    colour_nxt = colour_r;
    toggle_nxt = toggle_r;
    lit_nxt    = lit_r;
    if (item.req_type == lpc_pkg::REQ_TICK) begin
      if (blink_r && (elapsed >= 32'(period_r))) begin
        toggle_nxt = item.now_ms;
        lit_nxt    = !lit_r;
      end
    end else if (item.req_type == lpc_pkg::REQ_LINK && item.link_state != state_r) begin
      state_nxt = item.link_state;
      unique case (item.link_state)
        lpc_pkg::LINK_INIT: begin
          blink_nxt  = 1'b0;
          colour_nxt = lpc_pkg::COL_WHITE;
        end
        lpc_pkg::LINK_PREOP: begin
          blink_nxt  = 1'b1;
          colour_nxt = lpc_pkg::COL_BLUE;
        end
        lpc_pkg::LINK_OPER: begin
          blink_nxt  = 1'b0;
          colour_nxt = lpc_pkg::COL_BLUE;
        end
        lpc_pkg::LINK_STOPPED: begin
          blink_nxt  = 1'b0;
          colour_nxt = lpc_pkg::COL_RED;
        end
        default: begin
          // unmapped state: keep mode and colour
          blink_nxt  = blink_r;
          colour_nxt = colour_r;
        end
      endcase
      // restart the blink on any state change
      toggle_nxt = '0;
      lit_nxt    = 1'b1;
    end
  end

  assign rgb_nxt = lit_nxt ? colour_nxt : '0;

  // link state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= lpc_pkg::LINK_PERIOD_RST;
      state_r  <= lpc_pkg::LINK_INIT;
      blink_r  <= 1'b0;
      colour_r <= lpc_pkg::COL_WHITE;
      toggle_r <= '0;
      lit_r    <= 1'b1;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (step) begin
        state_r  <= state_nxt;
        blink_r  <= blink_nxt;
        colour_r <= colour_nxt;
        toggle_r <= toggle_nxt;
        lit_r    <= lit_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lpc_user_led.sv]
// ----------------------------------------------------------------------------
// lpc_user_led
// One user LED: off, solid, blink, heartbeat and one-shot modes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_user_led (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          sel,
  input  wire lpc_pkg::item_t                item,
  input  wire logic [lpc_pkg::PHASE_W-1:0]   phase,
  output logic                               lit_nxt
);

  logic [lpc_pkg::MODE_W-1:0]   mode_r,   mode_nxt;
  logic [lpc_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [lpc_pkg::NOW_W-1:0]    toggle_r, toggle_nxt;
  logic [lpc_pkg::NOW_W-1:0]    start_r,  start_nxt;
  logic                         lit_r;
  logic [lpc_pkg::NOW_W-1:0]    start_eff;
  logic [lpc_pkg::NOW_W-1:0]    blink_el;
  logic [lpc_pkg::NOW_W-1:0]    shot_el;

  // a zero start time counts as unset and takes the tick's time
  assign start_eff = (start_r == '0) ? item.now_ms : start_r;
  assign blink_el  = item.now_ms - toggle_r;
  assign shot_el   = item.now_ms - start_eff;

  // next LED state for the request in hand
  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    toggle_nxt = toggle_r;
    start_nxt  = start_r;
    lit_nxt    = lit_r;
    if (item.req_type == lpc_pkg::REQ_TICK) begin
      start_nxt = start_eff;
      unique case (mode_r)
        lpc_pkg::MODE_BLINK: begin
          if (blink_el >= period_r) begin
            toggle_nxt = item.now_ms;
            lit_nxt    = !lit_r;
          end
        end
        lpc_pkg::MODE_HEARTBEAT: begin
          lit_nxt = lpc_pkg::hb_lit(phase);
        end
        lpc_pkg::MODE_ONE_SHOT: begin
          if (shot_el < period_r) begin
            lit_nxt = 1'b1;
          end else if (lit_r) begin
            lit_nxt  = 1'b0;
            mode_nxt = lpc_pkg::MODE_OFF;
          end
        end
        default: begin
          lit_nxt = lit_r;
        end
      endcase
    end else if (sel) begin
      mode_nxt   = item.led_mode;
      period_nxt = item.interval_ms;
      start_nxt  = '0;
      if (item.led_mode == lpc_pkg::MODE_SOLID) begin
        lit_nxt = 1'b1;
      end else if (item.led_mode == lpc_pkg::MODE_OFF) begin
        lit_nxt = 1'b0;
      end
    end
  end

  // LED state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lpc_pkg::MODE_OFF;
      period_r <= '0;
      toggle_r <= '0;
      start_r  <= '0;
      lit_r    <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      period_r <= period_nxt;
      toggle_r <= toggle_nxt;
      start_r  <= start_nxt;
      lit_r    <= lit_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/led_pattern_controller_unit.sv]
// ----------------------------------------------------------------------------
// led_pattern_controller_unit
// Link-status RGB LED and user LED pattern generator.
// ----------------------------------------------------------------------------
// Each request (tick, link state change or user LED mode change) gives one
// response with the pin levels after the request is applied. Requests pass
// an input register, a stage holding the low bits of the quotient of now_ms
// by 1000 from a 32x32 reciprocal multiply (for the heartbeat phase), and
// then the update of all LED state into the response register. One request
// is taken per cycle while out_ready does not hold the output back. cfg_we
// writes the link blink period at once and should only be used while no
// request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_controller_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lpc_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lpc_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [lpc_pkg::NOW_W-1:0]       in_now_ms,
  input  wire logic [lpc_pkg::LINK_ST_W-1:0]   in_link_state,
  input  wire logic [lpc_pkg::IDX_W-1:0]       in_led_num,
  input  wire logic [lpc_pkg::MODE_W-1:0]      in_led_mode,
  input  wire logic [lpc_pkg::PERIOD_W-1:0]    in_interval_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lpc_pkg::RGB_W-1:0]            out_rgb_pins,
  output logic [lpc_pkg::USER_W-1:0]           out_user_pins
);

  lpc_pkg::item_t                          in_item;
  lpc_pkg::item_t                          s2_item;
  logic                                    s2_valid;
  logic [lpc_pkg::PHASE_W-1:0]             s2_phase;
  logic                                    step;
  logic                                    out_free;
  logic                                    out_vld_r;
  logic [lpc_pkg::RGB_W-1:0]               rgb_r;
  logic [lpc_pkg::USER_W-1:0]              user_r;
  logic [lpc_pkg::RGB_W-1:0]               rgb_nxt;
  logic [lpc_pkg::NUM_USER_LEDS-1:0]       lit_nxt;
  logic [lpc_pkg::USER_W-1:0]              user_nxt;

  // gather the request fields
  assign in_item = '{req_type:    in_req_type,
                     now_ms:      in_now_ms,
                     link_state:  in_link_state,
                     led_num:     in_led_num,
                     led_mode:    in_led_mode,
                     interval_ms: in_interval_ms};

  // apply a request once the response register is free
  assign out_free = !out_vld_r || out_ready;
  assign step     = s2_valid && out_free;

  lpc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s2_take  (step),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .s2_phase (s2_phase)
  );

  lpc_link u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (s2_item),
    .rgb_nxt   (rgb_nxt)
  );

  // one unit per user LED, selected by its number from 1
  for (genvar k = 0; k < lpc_pkg::NUM_USER_LEDS; k++) begin : g_user
    logic sel;

    assign sel = (s2_item.req_type == lpc_pkg::REQ_USER) &&
                 ({{(lpc_pkg::SEL_W - lpc_pkg::IDX_W){1'b0}}, s2_item.led_num} ==
                  lpc_pkg::SEL_W'(k + 1));

    lpc_user_led u_user_led (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .sel     (sel),
      .item    (s2_item),
      .phase   (s2_phase),
      .lit_nxt (lit_nxt[k])
    );
  end

  // map LED lit bits onto the user pins
  for (genvar b = 0; b < lpc_pkg::USER_W; b++) begin : g_pins
    if (b < lpc_pkg::NUM_USER_LEDS) begin : g_drv
      assign user_nxt[b] = lit_nxt[b];
    end else begin : g_zero
      assign user_nxt[b] = 1'b0;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s2_valid;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (step) begin
      rgb_r  <= rgb_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_rgb_pins  = rgb_r;
  assign out_user_pins = user_r;

endmodule

`default_nettype wire

[tb/sv/led_pattern_controller_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_controller_unit_test
// Self-checking test of the LED pattern controller.
// ----------------------------------------------------------------------------
// Sends tick, link state and user LED mode requests through the valid/ready
// input. Keeps its own model of the link LED and the user LEDs beside the
// block, and checks the pin levels of every response in order. Runs directed
// corner cases first, then random request streams at several link blink
// periods. These streams use idle gaps and stalls on both channels, a long
// hold-off on the output and timestamps that wrap.
// ----------------------------------------------------------------------------

module led_pattern_controller_unit_test;
  import lpc_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int MAX_REPORTS     = 20;

  // Codes outside the mapped ranges, and the number of the first user LED
  localparam logic [REQ_W-1:0]     REQ_UNKNOWN      = 2'd3;
  localparam logic [LINK_ST_W-1:0] LINK_UNMAPPED_LO = 3'd4;
  localparam logic [LINK_ST_W-1:0] LINK_UNMAPPED_HI = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_UNKNOWN_LO  = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_UNKNOWN_HI  = 3'd7;
  localparam logic [IDX_W-1:0]     LED_NONE         = 2'd0;
  localparam logic [IDX_W-1:0]     LED_FIRST        = 2'd1;

  typedef struct packed {
    logic [RGB_W-1:0]  rgb;
    logic [USER_W-1:0] user;
  } pins_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic [NOW_W-1:0]     in_now_ms;
  logic [LINK_ST_W-1:0] in_link_state;
  logic [IDX_W-1:0]     in_led_num;
  logic [MODE_W-1:0]    in_led_mode;
  logic [PERIOD_W-1:0]  in_interval_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [RGB_W-1:0]     out_rgb_pins;
  logic [USER_W-1:0]    out_user_pins;

  // Model of the LED state
  logic [CFG_W-1:0]     link_period_m;
  logic [LINK_ST_W-1:0] link_state_m;
  bit                   link_blinks_m;
  logic [RGB_W-1:0]     link_colour_m;
  logic [NOW_W-1:0]     link_toggle_m;
  bit                   link_lit_m;
  logic [MODE_W-1:0]    user_mode_m   [NUM_USER_LEDS];
  logic [PERIOD_W-1:0]  user_period_m [NUM_USER_LEDS];
  logic [NOW_W-1:0]     user_toggle_m [NUM_USER_LEDS];
  logic [NOW_W-1:0]     user_start_m  [NUM_USER_LEDS];
  bit                   user_lit_m    [NUM_USER_LEDS];

  pins_t       pending_pins[$];
  int          requests_taken;
  int          responses_seen;
  int          mismatches;
  int          input_stall_cycles;
  int          idle_cycles;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_off_request;
  int          hold_off_left;
  logic [NOW_W-1:0] clock_ms;
  int unsigned step_max;

  led_pattern_controller_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_now_ms      (in_now_ms),
    .in_link_state  (in_link_state),
    .in_led_num     (in_led_num),
    .in_led_mode    (in_led_mode),
    .in_interval_ms (in_interval_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rgb_pins   (out_rgb_pins),
    .out_user_pins  (out_user_pins)
  );

  always #CLK_HALF clk = ~clk;

  // Bring the model to its reset state
  task automatic reset_led_model();
    link_period_m = LINK_PERIOD_RST;
    link_state_m  = LINK_INIT;
    link_blinks_m = 1'b0;
    link_colour_m = COL_WHITE;
    link_toggle_m = '0;
    link_lit_m    = 1'b1;
    for (int k = 0; k < NUM_USER_LEDS; k++) begin
      user_mode_m[k]   = MODE_OFF;
      user_period_m[k] = '0;
      user_toggle_m[k] = '0;
      user_start_m[k]  = '0;
      user_lit_m[k]    = 1'b0;
    end
  endtask

  // Apply one request to the model and return the pins it leaves
  function automatic pins_t next_led_pins(input item_t req);
    pins_t            p;
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W-1:0] phase;
    int               k;
    case (req.req_type)
      REQ_TICK: begin
        elapsed = req.now_ms - link_toggle_m;
        if (link_blinks_m && elapsed >= NOW_W'(link_period_m)) begin
          link_toggle_m = req.now_ms;
          link_lit_m    = !link_lit_m;
        end
        for (k = 0; k < NUM_USER_LEDS; k++) begin
          // a zero start time counts as unset
          if (user_start_m[k] == '0) user_start_m[k] = req.now_ms;
          case (user_mode_m[k])
            MODE_BLINK: begin
              elapsed = req.now_ms - user_toggle_m[k];
              if (elapsed >= user_period_m[k]) begin
                user_toggle_m[k] = req.now_ms;
                user_lit_m[k]    = !user_lit_m[k];
              end
            end
            MODE_HEARTBEAT: begin
              phase = req.now_ms % NOW_W'(HB_CYCLE_MS);
              user_lit_m[k] = (phase < HB_ON1_END) ||
                              ((phase > HB_ON2_BEG) && (phase < HB_ON2_END));
            end
            MODE_ONE_SHOT: begin
              elapsed = req.now_ms - user_start_m[k];
              if (elapsed < user_period_m[k]) begin
                user_lit_m[k] = 1'b1;
              end else if (user_lit_m[k]) begin
                user_lit_m[k]  = 1'b0;
                user_mode_m[k] = MODE_OFF;
              end
            end
            default: ;
          endcase
        end
      end
      REQ_LINK: begin
        // a repeated state changes nothing; an unmapped one keeps colour and mode
        if (req.link_state != link_state_m) begin
          link_state_m = req.link_state;
          case (req.link_state)
            LINK_INIT: begin
              link_blinks_m = 1'b0;
              link_colour_m = COL_WHITE;
            end
            LINK_PREOP: begin
              link_blinks_m = 1'b1;
              link_colour_m = COL_BLUE;
            end
            LINK_OPER: begin
              link_blinks_m = 1'b0;
              link_colour_m = COL_BLUE;
            end
            LINK_STOPPED: begin
              link_blinks_m = 1'b0;
              link_colour_m = COL_RED;
            end
            default: ;
          endcase
          link_toggle_m = '0;
          link_lit_m    = 1'b1;
        end
      end
      REQ_USER: begin
        if (req.led_num != LED_NONE && req.led_num <= NUM_USER_LEDS) begin
          k = req.led_num - 1;
          user_mode_m[k]   = req.led_mode;
          user_period_m[k] = req.interval_ms;
          user_start_m[k]  = '0;
          if (req.led_mode == MODE_SOLID) user_lit_m[k] = 1'b1;
          else if (req.led_mode == MODE_OFF) user_lit_m[k] = 1'b0;
        end
      end
      default: ;
    endcase
    p.rgb  = link_lit_m ? link_colour_m : '0;
    p.user = '0;
    for (k = 0; k < NUM_USER_LEDS && k < USER_W; k++) begin
      if (user_lit_m[k]) p.user[k] = 1'b1;
    end
    return p;
  endfunction

  function automatic item_t make_request(input logic [REQ_W-1:0] kind,
                                         input logic [NOW_W-1:0] now,
                                         input logic [LINK_ST_W-1:0] link,
                                         input logic [IDX_W-1:0] led,
                                         input logic [MODE_W-1:0] mode,
                                         input logic [PERIOD_W-1:0] period);
    item_t req;
    req.req_type    = kind;
    req.now_ms      = now;
    req.link_state  = link;
    req.led_num     = led;
    req.led_mode    = mode;
    req.interval_ms = period;
    return req;
  endfunction

  // Mostly well-formed traffic on a running time base, with some noise
  function automatic item_t random_request();
    item_t       req;
    int unsigned pick;
    req.req_type    = REQ_TICK;
    req.now_ms      = $urandom;
    req.link_state  = LINK_ST_W'($urandom);
    req.led_num     = IDX_W'($urandom);
    req.led_mode    = MODE_W'($urandom);
    req.interval_ms = $urandom;
    pick = $urandom_range(99);
    if (pick < 58) begin
      // advance the time base; jump now and then, rarely to zero
      case ($urandom_range(99))
        0:       clock_ms = '0;
        1, 2, 3: clock_ms = $urandom;
        default: clock_ms = clock_ms + $urandom_range(step_max);
      endcase
      req.now_ms = clock_ms;
    end else if (pick < 72) begin
      req.req_type = REQ_LINK;
      if ($urandom_range(9) < 8) begin
        req.link_state = LINK_ST_W'($urandom_range(LINK_STOPPED));
      end else begin
        req.link_state = LINK_ST_W'($urandom_range(LINK_UNMAPPED_HI, LINK_UNMAPPED_LO));
      end
    end else if (pick < 94) begin
      req.req_type = REQ_USER;
      if ($urandom_range(9) == 0) req.led_num = LED_NONE;
      else req.led_num = IDX_W'($urandom_range(NUM_USER_LEDS, LED_FIRST));
      if ($urandom_range(9) == 0) begin
        req.led_mode = MODE_W'($urandom_range(MODE_UNKNOWN_HI, MODE_UNKNOWN_LO));
      end else begin
        req.led_mode = MODE_W'($urandom_range(MODE_ONE_SHOT));
      end
      case ($urandom_range(3))
        0:       req.interval_ms = $urandom_range(3);
        1:       req.interval_ms = $urandom_range(4 * step_max);
        2:       req.interval_ms = $urandom_range(1500);
        default: ;
      endcase
    end else if (pick < 97) begin
      req.req_type = REQ_UNKNOWN;
    end else begin
      req.req_type = REQ_W'($urandom);
    end
    return req;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= req.req_type;
    in_now_ms      <= req.now_ms;
    in_link_state  <= req.link_state;
    in_led_num     <= req.led_num;
    in_led_mode    <= req.led_mode;
    in_interval_ms <= req.interval_ms;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_requests(input int count);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  // Drop valid and wait until every response has come back
  task automatic end_of_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_link_period(input logic [CFG_W-1:0] period);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= period;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic flag_error(input string what, input int expd, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %0h, got %0h", $time, what, expd, got);
  endtask

  // Corner cases at the reset blink period of 500 ms
  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // a tick at time zero leaves every start time unset
    send_request(make_request(REQ_TICK, '0, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_UNKNOWN, '1, LINK_UNMAPPED_HI, '1, MODE_UNKNOWN_HI, '1));
    // repeated state, then blink in pre-operational
    send_request(make_request(REQ_LINK, '0, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_LINK, '0, LINK_PREOP, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd499, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd500, LINK_INIT, LED_NONE, MODE_OFF, '0));
    // unmapped states restart the blink but keep it blinking blue
    send_request(make_request(REQ_LINK, '0, LINK_UNMAPPED_LO, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_LINK, '0, LINK_UNMAPPED_HI, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd500, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_LINK, '0, LINK_OPER, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_LINK, '0, LINK_STOPPED, LED_NONE, MODE_OFF, '0));
    // user LED number zero is dropped
    send_request(make_request(REQ_USER, '0, LINK_INIT, LED_NONE, MODE_SOLID, '0));
    send_request(make_request(REQ_USER, '0, LINK_INIT, LED_FIRST, MODE_SOLID, '1));
    send_request(make_request(REQ_USER, '0, LINK_INIT, 2'd2, MODE_BLINK, '0));
    send_request(make_request(REQ_USER, '0, LINK_INIT, 2'd3, MODE_HEARTBEAT, '0));
    // largest time: zero-period blink toggles, heartbeat lit in its second pulse
    send_request(make_request(REQ_TICK, '1, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd250, LINK_INIT, LED_NONE, MODE_OFF, '0));
    // one-shot: start on the next tick, run out, then switch itself off
    send_request(make_request(REQ_USER, '0, LINK_INIT, 2'd3, MODE_ONE_SHOT, 32'd100));
    send_request(make_request(REQ_TICK, 32'd1000, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd1100, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_TICK, 32'd1200, LINK_INIT, LED_NONE, MODE_OFF, '0));
    // unknown user mode keeps the LED as it is
    send_request(make_request(REQ_USER, '0, LINK_INIT, LED_FIRST, MODE_UNKNOWN_LO, '0));
    send_request(make_request(REQ_TICK, 32'd1300, LINK_INIT, LED_NONE, MODE_OFF, '0));
    send_request(make_request(REQ_USER, '0, LINK_INIT, 2'd2, MODE_OFF, '1));
    send_request(make_request(REQ_LINK, '0, LINK_INIT, LED_NONE, MODE_OFF, '0));
    end_of_phase();
  endtask

  task automatic test_fast_link_blink();
    set_link_period(16'd1);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    step_max           = 4;
    send_random_requests(400);
    end_of_phase();
  endtask

  task automatic test_sender_gaps();
    set_link_period('1);
    sender_idle_pct    = 73;
    receiver_stall_pct = 0;
    step_max           = 30000;
    send_random_requests(350);
    end_of_phase();
  endtask

  task automatic test_receiver_stalls();
    set_link_period(CFG_W'($urandom_range(2000, 2)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 73;
    step_max           = 300;
    send_random_requests(350);
    end_of_phase();
  endtask

  task automatic test_both_sides_idle();
    set_link_period(LINK_PERIOD_RST);
    sender_idle_pct    = 35;
    receiver_stall_pct = 35;
    step_max           = 150;
    send_random_requests(350);
    end_of_phase();
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    set_link_period(CFG_W'($urandom_range(65535, 1)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    step_max           = 100;
    hold_off_request   = 1'b1;
    send_random_requests(150);
    end_of_phase();
  endtask

  task automatic test_timestamp_wrap();
    set_link_period(CFG_W'($urandom_range(1000, 1)));
    sender_idle_pct    = 35;
    receiver_stall_pct = 0;
    step_max           = 200;
    clock_ms           = 32'hFFFF_FFFF - $urandom_range(5000);
    send_random_requests(250);
    end_of_phase();
  endtask

  // Predict on each accepted request, check each accepted response
  always @(posedge clk) begin : response_check
    pins_t want;
    item_t seen;
    if (rst_n) begin
      if (cfg_we) link_period_m = cfg_wdata;
      if (in_valid && in_ready) begin
        seen = {in_req_type, in_now_ms, in_link_state, in_led_num, in_led_mode,
                in_interval_ms};
        pending_pins.push_back(next_led_pins(seen));
        requests_taken++;
      end
      if (in_valid && !in_ready) input_stall_cycles++;
      if (out_valid && out_ready) begin
        responses_seen++;
        if (pending_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: response with no request pending, expected none, got rgb %0h user %0h",
                     $time, out_rgb_pins, out_user_pins);
        end else begin
          want = pending_pins.pop_front();
          if (out_rgb_pins !== want.rgb)
            flag_error("rgb_pins", int'(want.rgb), int'(out_rgb_pins));
          if (out_user_pins !== want.user)
            flag_error("user_pins", int'(want.user), int'(out_user_pins));
        end
      end
    end
  end

  // Output ready: random stalls, or a counted hold-off when asked for
  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_off_left    = HOLD_OFF_CYCLES;
      hold_off_request = 1'b0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Stop a hung run: count cycles in which no request or response moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d responses outstanding",
               $time, WATCHDOG_LIMIT, pending_pins.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_TICK;
    in_now_ms      = '0;
    in_link_state  = LINK_INIT;
    in_led_num     = LED_NONE;
    in_led_mode    = MODE_OFF;
    in_interval_ms = '0;
    out_ready      = 1'b0;
    hold_off_request   = 1'b0;
    hold_off_left      = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    clock_ms           = '0;
    step_max           = 100;
    reset_led_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fast_link_blink();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_output_hold_off();
    test_timestamp_wrap();

    $display("Ran %0d requests and checked %0d responses at link blink periods of 1 to 65535 ms,",
             requests_taken, responses_seen);
    $display("with %0d cycles of input back-pressure and timestamps wrapping past the top.",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lpc_pkg.sv
rtl/lpc_in_stage.sv
rtl/lpc_link.sv
rtl/lpc_user_led.sv
rtl/led_pattern_controller_unit.sv
tb/sv/led_pattern_controller_unit_test.sv
